@@ design/lcd4_pkg.sv @@
// Shared types, constants and the pin program table for the 4-bit LCD write sequencer.
package lcd4_pkg;

    // Timer ticks per microsecond
    localparam int TICKS_PER_US = 1;

    // Strobe timing in microseconds
    localparam int EN_HIGH_US = 3;
    localparam int EN_LOW_US  = 50;
    localparam int STROBE_US  = EN_HIGH_US + EN_LOW_US;

    // Longest single operation (power-up wait)
    localparam int MAX_US = 20000;
    localparam int US_W   = $clog2(MAX_US + 1);
    localparam int CNT_W  = $clog2(MAX_US * TICKS_PER_US + 1);

    // Longest program is 16 operations
    localparam int PHASE_W = 4;

    // Command codes on the input word
    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_INSTR  = 3'd1,
        CMD_CHAR   = 3'd2,
        CMD_CURSOR = 3'd3,
        CMD_CLEAR  = 3'd4,
        CMD_INIT   = 3'd5
    } cmd_t;

    // Program being run
    typedef enum logic [2:0] {
        PROG_INSTR,
        PROG_CHAR,
        PROG_CURSOR,
        PROG_CLEAR,
        PROG_INIT
    } prog_t;

    // Operation kinds
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_SETNIB,
        OP_STROBE
    } op_kind_t;

    typedef struct packed {
        op_kind_t          kind;
        logic [3:0]        nib;
        logic              rs;
        logic [US_W-1:0]   us;
        logic              last;
    } op_t;

    // Per-tick pin result from the sequencer core
    typedef struct packed {
        logic       rs;
        logic       en;
        logic [3:0] nibble;
        logic       busy;
        logic       rejected;
    } lcd4_res_t;

    // DDRAM base address of each display row
    function automatic logic [7:0] row_base(input logic [1:0] row);
        logic [7:0] base;
        unique case (row)
            2'd0:    base = 8'h80;
            2'd1:    base = 8'hC0;
            2'd2:    base = 8'h94;
            default: base = 8'hD4;
        endcase
        return base;
    endfunction

    function automatic op_t make_op(input op_kind_t kind, input logic [3:0] nib,
                                    input logic rs, input int us, input logic last);
        op_t op;
        op.kind = kind;
        op.nib  = nib;
        op.rs   = rs;
        op.us   = US_W'(us);
        op.last = last;
        return op;
    endfunction

    function automatic op_t hold_op(input int us, input logic last);
        return make_op(OP_HOLD, 4'h0, 1'b0, us, last);
    endfunction

    function automatic op_t strobe_op(input logic [3:0] nib, input logic rs, input logic last);
        return make_op(OP_STROBE, nib, rs, STROBE_US, last);
    endfunction

    // Operation at a given step of a program
    function automatic op_t op_lookup(input prog_t prog, input logic [PHASE_W-1:0] phase,
                                      input logic [7:0] pbyte);
        op_t op;
        op = hold_op(1, 1'b1);
        unique case (prog)
            PROG_INSTR, PROG_CHAR:
            begin
                if (phase == PHASE_W'(0))
                    op = strobe_op(pbyte[7:4], prog == PROG_CHAR, 1'b0);
                else
                    op = strobe_op(pbyte[3:0], prog == PROG_CHAR, 1'b1);
            end
            PROG_CURSOR:
            begin
                case (phase)
                    PHASE_W'(0): op = hold_op(300, 1'b0);
                    PHASE_W'(1): op = strobe_op(pbyte[7:4], 1'b0, 1'b0);
                    PHASE_W'(2): op = strobe_op(pbyte[3:0], 1'b0, 1'b0);
                    default:     op = hold_op(50, 1'b1);
                endcase
            end
            PROG_CLEAR:
            begin
                case (phase)
                    PHASE_W'(0): op = strobe_op(4'h0, 1'b0, 1'b0);
                    PHASE_W'(1): op = strobe_op(4'h1, 1'b0, 1'b0);
                    default:     op = hold_op(10000, 1'b1);
                endcase
            end
            default:
            begin
                case (phase)
                    PHASE_W'(0):  op = make_op(OP_SETNIB, 4'h0, 1'b0, 20000, 1'b0);
                    PHASE_W'(1):  op = strobe_op(4'h3, 1'b0, 1'b0);
                    PHASE_W'(2):  op = hold_op(5000, 1'b0);
                    PHASE_W'(3):  op = strobe_op(4'h3, 1'b0, 1'b0);
                    PHASE_W'(4):  op = hold_op(100, 1'b0);
                    PHASE_W'(5):  op = strobe_op(4'h3, 1'b0, 1'b0);
                    PHASE_W'(6):  op = strobe_op(4'h2, 1'b0, 1'b0);
                    PHASE_W'(7):  op = strobe_op(4'h2, 1'b0, 1'b0);
                    PHASE_W'(8):  op = strobe_op(4'h8, 1'b0, 1'b0);
                    PHASE_W'(9):  op = strobe_op(4'h0, 1'b0, 1'b0);
                    PHASE_W'(10): op = strobe_op(4'hC, 1'b0, 1'b0);
                    PHASE_W'(11): op = strobe_op(4'h0, 1'b0, 1'b0);
                    PHASE_W'(12): op = strobe_op(4'h6, 1'b0, 1'b0);
                    PHASE_W'(13): op = strobe_op(4'h0, 1'b0, 1'b0);
                    PHASE_W'(14): op = strobe_op(4'h1, 1'b0, 1'b0);
                    default:      op = hold_op(10000, 1'b1);
                endcase
            end
        endcase
        return op;
    endfunction

    // Index of the final operation of each program
    function automatic logic [PHASE_W-1:0] last_phase(input prog_t prog);
        logic [PHASE_W-1:0] idx;
        unique case (prog)
            PROG_INSTR, PROG_CHAR: idx = PHASE_W'(1);
            PROG_CURSOR:           idx = PHASE_W'(3);
            PROG_CLEAR:            idx = PHASE_W'(2);
            default:               idx = PHASE_W'(15);
        endcase
        return idx;
    endfunction

endpackage

@@ design/lcd4_seq_core.sv @@
// Sequencer state and per-tick pin logic for the 4-bit LCD write sequencer.
module lcd4_seq_core
    import lcd4_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [2:0] cmd,
    input  logic [7:0] value,
    input  logic [5:0] column,
    input  logic [1:0] row,
    output lcd4_res_t  res
);

    logic               busy_reg,    busy_next;
    prog_t              prog_reg,    prog_next;
    logic [PHASE_W-1:0] phase_reg,   phase_next;
    logic [CNT_W-1:0]   elapsed_reg, elapsed_next;
    logic [7:0]         byte_reg,    byte_next;
    logic [3:0]         nibble_reg,  nibble_next;

    logic               req;
    logic               start;
    prog_t              prog_cur;
    logic [PHASE_W-1:0] phase_cur;
    logic [CNT_W-1:0]   elapsed_cur;
    logic [7:0]         byte_cur;
    op_t                op;
    logic [CNT_W-1:0]   total;
    logic               op_done;

    // Request decode
    always_comb
    begin
        req      = 1'b0;
        prog_cur = prog_reg;
        byte_cur = byte_reg;
        unique case (cmd)
            CMD_INSTR:
            begin
                req      = 1'b1;
                prog_cur = PROG_INSTR;
                byte_cur = value;
            end
            CMD_CHAR:
            begin
                req      = 1'b1;
                prog_cur = PROG_CHAR;
                byte_cur = value;
            end
            CMD_CURSOR:
            begin
                req      = 1'b1;
                prog_cur = PROG_CURSOR;
                byte_cur = row_base(row) + {2'b00, column};
            end
            CMD_CLEAR:
            begin
                req      = 1'b1;
                prog_cur = PROG_CLEAR;
                byte_cur = 8'h01;
            end
            CMD_INIT:
            begin
                req      = 1'b1;
                prog_cur = PROG_INIT;
                byte_cur = 8'h01;
            end
            default:
            begin
                req = 1'b0;
            end
        endcase
        start = req && !busy_reg;
        if (!start)
        begin
            prog_cur = prog_reg;
            byte_cur = byte_reg;
        end
    end

    // Current operation; a starting program runs its first tick at once
    assign phase_cur   = start ? '0 : phase_reg;
    assign elapsed_cur = start ? '0 : elapsed_reg;
    assign op          = op_lookup(prog_cur, phase_cur, byte_cur);
    assign total       = CNT_W'(op.us * TICKS_PER_US);
    assign op_done     = (elapsed_cur == total - CNT_W'(1));

    // Pin levels and next state
    always_comb
    begin
        busy_next    = busy_reg;
        prog_next    = prog_cur;
        phase_next   = phase_cur;
        elapsed_next = elapsed_cur;
        byte_next    = byte_cur;
        nibble_next  = nibble_reg;
        res.rs       = 1'b0;
        res.en       = 1'b0;
        res.busy     = 1'b0;
        res.rejected = req && busy_reg;
        if (busy_reg || start)
        begin
            res.busy = 1'b1;
            res.rs   = op.rs;
            if (op.kind != OP_HOLD)
                nibble_next = op.nib;
            if (op.kind == OP_STROBE)
                res.en = (elapsed_cur < CNT_W'(EN_HIGH_US * TICKS_PER_US));
            if (op_done)
            begin
                elapsed_next = '0;
                if (op.last)
                begin
                    busy_next  = 1'b0;
                    phase_next = '0;
                end
                else
                begin
                    busy_next  = 1'b1;
                    phase_next = phase_cur + PHASE_W'(1);
                end
            end
            else
            begin
                busy_next    = 1'b1;
                elapsed_next = elapsed_cur + CNT_W'(1);
            end
        end
        res.nibble = nibble_next;
    end

    // State registers advance once per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            prog_reg    <= PROG_INSTR;
            phase_reg   <= '0;
            elapsed_reg <= '0;
            byte_reg    <= '0;
            nibble_reg  <= '0;
        end
        else if (step)
        begin
            busy_reg    <= busy_next;
            prog_reg    <= prog_next;
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            byte_reg    <= byte_next;
            nibble_reg  <= nibble_next;
        end
    end

`ifndef ASSERT_OFF
    // A running program never steps past its last operation
    a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (phase_reg <= last_phase(prog_reg)))
        else $error("phase past end of program");

    // Elapsed count stays inside the current operation
    a_elapsed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (elapsed_reg < total))
        else $error("elapsed count overran operation");

    // Strobe only while a program runs; a rejected request never starts one
    a_en_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res.en |-> res.busy)
        else $error("enable strobe while idle");

    // A rejected request leaves the running program untouched
    a_reject_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res.rejected) |=> (prog_reg == $past(prog_reg)
                                    && byte_reg == $past(byte_reg)))
        else $error("rejected request changed program");

    // Without an accepted tick the sequencer holds still
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> ($stable(elapsed_reg) && $stable(phase_reg) && $stable(busy_reg)))
        else $error("sequencer advanced without a tick");
`endif

endmodule

@@ design/lcd_4bit_write_sequencer_unit.sv @@
// Top level of the 4-bit character LCD write sequencer: handshake and result register.
//
// Usage:
//   Each input word is one timer tick (TICKS_PER_US ticks per microsecond) and may
//   carry a request in cmd: instruction byte, character byte, set cursor
//   (row/column), clear, or power-up init. An idle sequencer starts the request's
//   pin program on the same tick; a request arriving while a program runs is
//   dropped and flagged by rejected on that tick's result word.
//   Every accepted input word yields exactly one result word with the pin levels
//   (pin_rs, pin_rw, pin_en, pin_nibble) and busy_res for that tick.
// Latency and throughput:
//   One result register: a result word is offered in the cycle after its input
//   word is accepted. One input word per cycle is taken while the result register is
//   empty or being drained, so the sustained rate is one word per cycle.
// Reset:
//   rst_n clears the sequencer to idle and the result register empty; the result payload is not reset.
// Stall:
//   While out_ready is low with a result waiting, in_ready drops and the sequencer
//   does not advance; the pin timing counts accepted ticks only.
module lcd_4bit_write_sequencer_unit
    import lcd4_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] cmd,
    input  logic [7:0] value,
    input  logic [5:0] column,
    input  logic [1:0] row,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       pin_rs,
    output logic       pin_rw,
    output logic       pin_en,
    output logic [3:0] pin_nibble,
    output logic       busy_res,
    output logic       rejected
);

    logic      step;
    lcd4_res_t res;
    lcd4_res_t res_reg;
    logic      out_valid_reg, out_valid_next;

    // Accept a tick whenever the result register is free or draining
    assign in_ready = !out_valid_reg || out_ready;
    assign step     = in_valid && in_ready;

    lcd4_seq_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .cmd    (cmd),
        .value  (value),
        .column (column),
        .row    (row),
        .res    (res)
    );

    // Result register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (step)
            res_reg <= res;
    end

    assign out_valid  = out_valid_reg;
    assign pin_rs     = res_reg.rs;
    assign pin_rw     = 1'b0;
    assign pin_en     = res_reg.en;
    assign pin_nibble = res_reg.nibble;
    assign busy_res   = res_reg.busy;
    assign rejected   = res_reg.rejected;

`ifndef ASSERT_OFF
    // An unaccepted result word stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg)
        else $error("result word dropped before taken");

    // Input is taken only when the result register can hold the new word
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        step |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten");

    // Every accepted tick produces a result word next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("accepted tick without result");
`endif

endmodule

@@ dv/lcd4_pin_checker.sv @@
// Pin word predictor and result checker for the 4-bit LCD write sequencer.
module lcd4_pin_checker
    import lcd4_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [2:0] cmd,
    input  logic [7:0] value,
    input  logic [5:0] column,
    input  logic [1:0] row,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic       pin_rs,
    input  logic       pin_rw,
    input  logic       pin_en,
    input  logic [3:0] pin_nibble,
    input  logic       busy_res,
    input  logic       rejected,
    output int         mismatches,
    output int         outstanding
);

    // Program timing in microseconds
    localparam int unsigned CURSOR_PRE_US  = 300;
    localparam int unsigned CURSOR_POST_US = 50;
    localparam int unsigned CLEAR_WAIT_US  = 10000;
    localparam int unsigned POWER_UP_US    = 20000;
    localparam int unsigned WAKE_WAIT1_US  = 5000;
    localparam int unsigned WAKE_WAIT2_US  = 100;

    // Bytes and nibbles of the power-up sequence
    localparam logic [7:0] FUNC_SET_4BIT = 8'h28;
    localparam logic [7:0] DISPLAY_ON    = 8'h0C;
    localparam logic [7:0] ENTRY_INC     = 8'h06;
    localparam logic [7:0] CLEAR_DISPLAY = 8'h01;
    localparam logic [3:0] WAKE_NIB      = 4'h3;
    localparam logic [3:0] MODE4_NIB     = 4'h2;

    // DDRAM address of column 0 on each row
    localparam logic [7:0] ROW_ADDR [4] = '{8'h80, 8'hC0, 8'h94, 8'hD4};

    localparam int unsigned SEQ_DEPTH = 16;

    typedef struct {
        op_kind_t    kind;
        logic [3:0]  nib;
        logic        rs;
        int unsigned ticks;
    } pin_op_s;

    typedef struct packed {
        logic       rs;
        logic       rw;
        logic       en;
        logic [3:0] nibble;
        logic       busy;
        logic       rejected;
    } pin_word_s;

    // Sequencer state as predicted
    pin_op_s     seq_ops [SEQ_DEPTH];
    int unsigned seq_len;
    int unsigned seq_idx;
    int unsigned ticks_left;
    logic        rs_lvl;
    logic        en_lvl;
    logic [3:0]  nib_lvl;

    pin_word_s   expected_pins [$];
    pin_word_s   want;
    int          words_seen;

    function automatic void append_op(input op_kind_t kind, input logic [3:0] nib,
                                      input logic rs, input int unsigned us);
        if (seq_len < SEQ_DEPTH)
        begin
            seq_ops[seq_len].kind  = kind;
            seq_ops[seq_len].nib   = nib;
            seq_ops[seq_len].rs    = rs;
            seq_ops[seq_len].ticks = us * TICKS_PER_US;
            seq_len++;
        end
    endfunction

    // High nibble first, then low nibble
    function automatic void append_byte(input logic [7:0] b, input logic rs);
        append_op(OP_STROBE, b[7:4], rs, STROBE_US);
        append_op(OP_STROBE, b[3:0], rs, STROBE_US);
    endfunction

    function automatic void load_program(input logic [2:0] c, input logic [7:0] v,
                                         input logic [5:0] col, input logic [1:0] r);
        logic [7:0] addr;
        seq_len = 0;
        case (c)
            CMD_INSTR:  append_byte(v, 1'b0);
            CMD_CHAR:   append_byte(v, 1'b1);
            CMD_CURSOR:
            begin
                // address wraps at 8 bits
                addr = ROW_ADDR[r] + {2'b00, col};
                append_op(OP_HOLD, 4'h0, 1'b0, CURSOR_PRE_US);
                append_byte(addr, 1'b0);
                append_op(OP_HOLD, 4'h0, 1'b0, CURSOR_POST_US);
            end
            CMD_CLEAR:
            begin
                append_byte(CLEAR_DISPLAY, 1'b0);
                append_op(OP_HOLD, 4'h0, 1'b0, CLEAR_WAIT_US);
            end
            default:
            begin
                append_op(OP_SETNIB, 4'h0, 1'b0, POWER_UP_US);
                append_op(OP_STROBE, WAKE_NIB, 1'b0, STROBE_US);
                append_op(OP_HOLD, 4'h0, 1'b0, WAKE_WAIT1_US);
                append_op(OP_STROBE, WAKE_NIB, 1'b0, STROBE_US);
                append_op(OP_HOLD, 4'h0, 1'b0, WAKE_WAIT2_US);
                append_op(OP_STROBE, WAKE_NIB, 1'b0, STROBE_US);
                append_op(OP_STROBE, MODE4_NIB, 1'b0, STROBE_US);
                append_byte(FUNC_SET_4BIT, 1'b0);
                append_byte(DISPLAY_ON, 1'b0);
                append_byte(ENTRY_INC, 1'b0);
                append_byte(CLEAR_DISPLAY, 1'b0);
                append_op(OP_HOLD, 4'h0, 1'b0, CLEAR_WAIT_US);
            end
        endcase
        seq_idx    = 0;
        ticks_left = seq_ops[0].ticks;
    endfunction

    // One timer tick: start or reject a request, then run one tick of the program
    function automatic pin_word_s tick_step(input logic [2:0] c, input logic [7:0] v,
                                            input logic [5:0] col, input logic [1:0] r);
        pin_word_s   w;
        int unsigned elapsed;
        w = '0;
        if (c >= CMD_INSTR && c <= CMD_INIT)
        begin
            if (seq_idx < seq_len)
                w.rejected = 1'b1;
            else
                load_program(c, v, col, r);
        end
        if (seq_idx < seq_len)
        begin
            elapsed = seq_ops[seq_idx].ticks - ticks_left;
            en_lvl  = 1'b0;
            if (seq_ops[seq_idx].kind != OP_HOLD)
                nib_lvl = seq_ops[seq_idx].nib;
            if (seq_ops[seq_idx].kind == OP_STROBE)
                en_lvl = (elapsed < EN_HIGH_US * TICKS_PER_US);
            rs_lvl = seq_ops[seq_idx].rs;
            w.busy = 1'b1;
            if (ticks_left > 0)
                ticks_left--;
            if (ticks_left == 0)
            begin
                seq_idx++;
                if (seq_idx < seq_len)
                    ticks_left = seq_ops[seq_idx].ticks;
                else
                begin
                    seq_len = 0;
                    seq_idx = 0;
                end
            end
        end
        else
        begin
            // idle: strobe and RS low, data lines hold
            en_lvl = 1'b0;
            rs_lvl = 1'b0;
        end
        w.rs     = rs_lvl;
        w.rw     = 1'b0;
        w.en     = en_lvl;
        w.nibble = nib_lvl;
        return w;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int exp_v);
        mismatches++;
        if (mismatches <= 100)
            $display("mismatch at result word %0d: %s got %0h, expected %0h",
                     words_seen, what, got, exp_v);
    endtask

    // Compare the outgoing word first, then predict for the incoming one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_len     = 0;
            seq_idx     = 0;
            ticks_left  = 0;
            rs_lvl      = 1'b0;
            en_lvl      = 1'b0;
            nib_lvl     = 4'h0;
            words_seen  = 0;
            mismatches  = 0;
            outstanding = 0;
            expected_pins.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_pins.size() == 0)
                    flag_mismatch("word with none expected", 1, 0);
                else
                begin
                    want = expected_pins.pop_front();
                    if (pin_rs !== want.rs)
                        flag_mismatch("pin_rs", pin_rs, want.rs);
                    if (pin_rw !== want.rw)
                        flag_mismatch("pin_rw", pin_rw, want.rw);
                    if (pin_en !== want.en)
                        flag_mismatch("pin_en", pin_en, want.en);
                    if (pin_nibble !== want.nibble)
                        flag_mismatch("pin_nibble", pin_nibble, want.nibble);
                    if (busy_res !== want.busy)
                        flag_mismatch("busy_res", busy_res, want.busy);
                    if (rejected !== want.rejected)
                        flag_mismatch("rejected", rejected, want.rejected);
                end
                words_seen++;
            end
            if (in_valid && in_ready)
                expected_pins.push_back(tick_step(cmd, value, column, row));
            outstanding = expected_pins.size();
        end
    end

endmodule

@@ dv/tb.sv @@
// Testbench top for the 4-bit LCD write sequencer: tick stimulus, result drain and verdict.
module tb
    import lcd4_pkg::*;
();

    localparam int CYCLE_LIMIT  = 200_000;
    localparam int ITEM_BUDGET  = 1450;
    localparam int TAIL_WORDS   = 120;
    localparam int DRAIN_CYCLES = 8;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [2:0] cmd;
    logic [7:0] value;
    logic [5:0] column;
    logic [1:0] row;
    logic       out_valid;
    logic       out_ready;
    logic       pin_rs;
    logic       pin_rw;
    logic       pin_en;
    logic [3:0] pin_nibble;
    logic       busy_res;
    logic       rejected;

    int mismatches;
    int outstanding;
    int cycle_count;
    int words_sent;
    bit tx_idle;

    lcd_4bit_write_sequencer_unit dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .value      (value),
        .column     (column),
        .row        (row),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pin_rs     (pin_rs),
        .pin_rw     (pin_rw),
        .pin_en     (pin_en),
        .pin_nibble (pin_nibble),
        .busy_res   (busy_res),
        .rejected   (rejected)
    );

    lcd4_pin_checker pin_chk
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .value       (value),
        .column      (column),
        .row         (row),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pin_rs      (pin_rs),
        .pin_rw      (pin_rw),
        .pin_en      (pin_en),
        .pin_nibble  (pin_nibble),
        .busy_res    (busy_res),
        .rejected    (rejected),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Watchdog
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[lcd_4bit_write_sequencer_unit] ERROR");
            $finish;
        end
    end

    // Ticks a request keeps the sequencer busy
    function automatic int busy_ticks(input logic [2:0] c);
        case (c)
            CMD_INSTR, CMD_CHAR: return 2 * STROBE_US * TICKS_PER_US;
            CMD_CURSOR:          return (300 + 2 * STROBE_US + 50) * TICKS_PER_US;
            CMD_CLEAR:           return (2 * STROBE_US + 10000) * TICKS_PER_US;
            CMD_INIT:            return (20000 + 5000 + 100 + 12 * STROBE_US + 10000)
                                        * TICKS_PER_US;
            default:             return 0;
        endcase
    endfunction

    // Offer one word; entered and left at a falling edge
    task automatic push_word(input logic [2:0] c, input logic [7:0] v,
                             input logic [5:0] col, input logic [1:0] r);
        int gap;
        gap = tx_idle ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        value    <= v;
        column   <= col;
        row      <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
        @(negedge clk);
    endtask

    // Request word followed by a run of tick words, with stray requests mixed in
    task automatic issue_request(input logic [2:0] c, input logic [7:0] v,
                                 input logic [5:0] col, input logic [1:0] r,
                                 input int after, input int odds);
        push_word(c, v, col, r);
        repeat (after)
        begin
            if (odds > 0 && $urandom_range(1, odds) == 1)
                push_word(3'($urandom_range(1, 7)), 8'($urandom), 6'($urandom),
                          2'($urandom));
            else
                push_word(CMD_TICK, 8'($urandom), 6'($urandom), 2'($urandom));
        end
    endtask

    // Stimulus
    initial
    begin
        int nom;
        int after;
        int odds;
        int pick;
        int room;
        logic [2:0] c;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        cmd      = CMD_TICK;
        value    = 8'h00;
        column   = 6'd0;
        row      = 2'd0;
        tx_idle  = 1'b0;
        words_sent = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Byte extremes, each next request on the first idle tick
        issue_request(CMD_INSTR, 8'h00, 6'd0, 2'd0, busy_ticks(CMD_INSTR) - 1, 0);
        issue_request(CMD_INSTR, 8'hFF, 6'd63, 2'd3, busy_ticks(CMD_INSTR) - 1, 0);
        tx_idle = 1'b1;
        issue_request(CMD_CHAR, 8'hFF, 6'd0, 2'd0, busy_ticks(CMD_CHAR) - 1, 0);
        issue_request(CMD_CHAR, 8'h00, 6'd63, 2'd3, busy_ticks(CMD_CHAR) - 1, 0);

        // Request on the last busy tick is rejected
        issue_request(CMD_CHAR, 8'h5A, 6'd0, 2'd0, busy_ticks(CMD_CHAR) - 2, 0);
        issue_request(CMD_INSTR, 8'h33, 6'd0, 2'd0, 4, 0);

        // Unused codes act as plain ticks
        issue_request(3'd6, 8'hA5, 6'd21, 2'd1, 0, 0);
        issue_request(3'd7, 8'h5A, 6'd42, 2'd2, 2, 0);

        // Cursor with address wrap
        tx_idle = 1'b0;
        issue_request(CMD_CURSOR, 8'h00, 6'd44, 2'd3, busy_ticks(CMD_CURSOR) - 1, 0);

        // Random requests, mostly landing near the end of the running program
        while (words_sent < ITEM_BUDGET - TAIL_WORDS)
        begin
            tx_idle = ($urandom_range(0, 2) == 0);
            pick    = $urandom_range(0, 99);
            if (pick < 45)
                c = CMD_INSTR;
            else if (pick < 85)
                c = CMD_CHAR;
            else if (pick < 95)
                c = CMD_CURSOR;
            else
                c = 3'($urandom_range(6, 7));

            nom  = busy_ticks(c);
            pick = $urandom_range(0, 19);
            if (pick < 3)
                after = $urandom_range(0, nom / 2);
            else if (pick < 6)
                after = nom + $urandom_range(0, 40);
            else
                after = nom - 3 + $urandom_range(0, 4);
            room = ITEM_BUDGET - TAIL_WORDS - words_sent - 1;
            if (after > room)
                after = room;
            if (after < 0)
                after = 0;
            odds = 16;
            issue_request(c, 8'($urandom), 6'($urandom), 2'($urandom), after, odds);
        end

        // Clear, with an init request rejected during its wait
        tx_idle = 1'b1;
        issue_request(CMD_CLEAR, 8'hFF, 6'd63, 2'd3, 2 * STROBE_US + 1, 0);
        issue_request(CMD_INIT, 8'h00, 6'd0, 2'd0, 8, 0);
        in_valid <= 1'b0;

        // Drain, then let the result register settle
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("[lcd_4bit_write_sequencer_unit] OK");
        else
            $display("[lcd_4bit_write_sequencer_unit] ERROR");
        $finish;
    end

    // Result drain with random stalls and an occasional long hold-off
    initial
    begin
        int stall;
        int taken;
        bit rx_idle;

        out_ready = 1'b0;
        taken     = 0;
        rx_idle   = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (taken % 50 == 0)
                rx_idle = ($urandom_range(0, 2) == 0);
            stall = rx_idle ? $urandom_range(0, 8) : 0;
            // hold off long enough for the input side to back up
            if (taken % 30000 == 300)
                stall = 400;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            taken++;
            @(negedge clk);
        end
    end

endmodule

@@ lcd_4bit_write_sequencer_unit.f @@
design/lcd4_pkg.sv
design/lcd4_seq_core.sv
design/lcd_4bit_write_sequencer_unit.sv
dv/lcd4_pin_checker.sv
dv/tb.sv
